FILE: rtl/spi_fifo_refill_planner_unit_defines.svh
// Assertion macros shared by the SPI FIFO refill planner checker
`ifndef SPI_FIFO_REFILL_PLANNER_UNIT_DEFINES_SVH
`define SPI_FIFO_REFILL_PLANNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SFRP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define SFRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sfrp_pkg.sv
// Types and constants for the SPI FIFO refill planner
`default_nettype none

package sfrp_pkg;

	localparam logic       MODE_START   = 1'b0;
	localparam logic       MODE_SERVICE = 1'b1;
	localparam logic [4:0] IRQ_STATUS_MASK = 5'h1f;
	localparam logic [8:0] DEPTH_MIN    = 9'd2;
	localparam logic [8:0] DEPTH_RESET  = 9'd16;

	// One request item
	typedef struct packed {
		logic        mode;
		logic [15:0] word_count;
		logic [4:0]  irq_pending;
		logic [8:0]  tx_level;
		logic [8:0]  rx_level;
	} sfrp_req_t;

	// One result item
	typedef struct packed {
		logic [8:0] read_count;
		logic [8:0] write_count;
		logic [8:0] rx_threshold;
		logic       rx_threshold_valid;
		logic [7:0] tx_threshold;
		logic       tx_empty_irq_on;
		logic       rx_full_irq_on;
		logic       done_res;
	} sfrp_rsp_t;

	// Transfer bookkeeping
	typedef struct packed {
		logic [15:0] tx_words_left;
		logic [15:0] rx_words_left;
		logic        tx_irq_enabled;
		logic        rx_irq_enabled;
		logic        busy;
	} sfrp_state_t;

endpackage

`default_nettype wire

FILE: rtl/sfrp_calc.sv
// Combinational planning step: result and next transfer state for one request
`default_nettype none

module sfrp_calc
	import sfrp_pkg::*;
(
	input  sfrp_req_t   req,
	input  sfrp_state_t st,
	input  logic [8:0]  depth,
	output sfrp_rsp_t   rsp,
	output sfrp_state_t st_nxt
);

	logic [4:0]  pend;
	logic [7:0]  half;
	logic [8:0]  rd;
	logic [15:0] rx_left_rd;
	logic [15:0] rx_left_m1;
	logic [8:0]  lvl;
	logic [8:0]  room;
	logic [15:0] gap;
	logic [8:0]  gap_room;
	logic [8:0]  lim;
	logic [8:0]  wr;
	logic [15:0] tx_left_wr;

	assign pend = req.irq_pending & IRQ_STATUS_MASK;
	assign half = depth[8:1];

	// Drain: min(rx words left, rx level)
	assign rd = (st.rx_words_left < {7'd0, req.rx_level}) ?
		st.rx_words_left[8:0] : req.rx_level;
	assign rx_left_rd = st.rx_words_left - {7'd0, rd};
	assign rx_left_m1 = rx_left_rd - 16'd1;
	assign lvl = (rx_left_m1 < {7'd0, depth}) ? rx_left_m1[8:0] : depth;

	// Push limits, each difference clamped at zero
	assign room = (depth > req.tx_level) ? (depth - req.tx_level) : 9'd0;
	assign gap = (rx_left_rd > st.tx_words_left) ? (rx_left_rd - st.tx_words_left) : 16'd0;
	assign gap_room = (gap < {7'd0, depth}) ? (depth - gap[8:0]) : 9'd0;
	assign lim = (room < gap_room) ? room : gap_room;
	assign wr = (st.tx_words_left < {7'd0, lim}) ? st.tx_words_left[8:0] : lim;
	assign tx_left_wr = st.tx_words_left - {7'd0, wr};

	always_comb begin
		st_nxt = st;
		rsp = '0;
		if (req.mode == MODE_START) begin
			if (req.word_count != 16'd0) begin
				st_nxt.tx_words_left = req.word_count;
				st_nxt.rx_words_left = req.word_count;
				st_nxt.tx_irq_enabled = 1'b1;
				st_nxt.rx_irq_enabled = 1'b0;
				st_nxt.busy = 1'b1;
				rsp.tx_threshold = ({8'd0, half} < req.word_count) ?
					half : req.word_count[7:0];
			end
		end else if (pend != 5'd0 && st.busy) begin
			rsp.read_count = rd;
			st_nxt.rx_words_left = rx_left_rd;
			if (rx_left_rd == 16'd0) begin
				// last word drained: transfer complete
				st_nxt.tx_words_left = 16'd0;
				st_nxt.tx_irq_enabled = 1'b0;
				st_nxt.rx_irq_enabled = 1'b0;
				st_nxt.busy = 1'b0;
				rsp.done_res = 1'b1;
			end else if (st.tx_words_left == 16'd0) begin
				rsp.rx_threshold = lvl;
				rsp.rx_threshold_valid = 1'b1;
			end else begin
				rsp.write_count = wr;
				st_nxt.tx_words_left = tx_left_wr;
				if (tx_left_wr == 16'd0) begin
					// all sent: hand over to the receive-full interrupt
					st_nxt.tx_irq_enabled = 1'b0;
					st_nxt.rx_irq_enabled = 1'b1;
					rsp.rx_threshold = lvl;
					rsp.rx_threshold_valid = 1'b1;
				end
			end
		end
		rsp.tx_empty_irq_on = st_nxt.tx_irq_enabled;
		rsp.rx_full_irq_on = st_nxt.rx_irq_enabled;
	end

endmodule

`default_nettype wire

FILE: rtl/spi_fifo_refill_planner_unit.sv
// Input register, one planning step, result register; the result drives out_data.
// Throughput: one request per cycle while out_ready does not stall the result register.
// in_ready is high while the input register is empty or its request moves on this cycle.
// Reset (arst_n low, asynchronous): transfer idle, counts and enables zero,
// FIFO depth 16 (saturated to 2..MAX_FIFO_DEPTH).
`default_nettype none

module spi_fifo_refill_planner_unit
	import sfrp_pkg::*;
#(
	parameter int MAX_FIFO_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sfrp_req_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output sfrp_rsp_t  out_data,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);

	localparam logic [8:0] DEPTH_MAX = 9'(MAX_FIFO_DEPTH);
	localparam logic [8:0] DEPTH_INIT = (DEPTH_RESET > DEPTH_MAX) ? DEPTH_MAX : DEPTH_RESET;

	sfrp_req_t   req_s1;
	logic        valid_s1;
	sfrp_rsp_t   rsp_s2;
	logic        valid_s2;
	sfrp_state_t state_q;
	sfrp_state_t state_nxt;
	sfrp_rsp_t   rsp_nxt;
	logic [8:0]  depth_q;
	logic [8:0]  depth_sat;
	logic        advance;

	// Result register free or emptied this cycle
	assign advance = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data = rsp_s2;

	// Depth register, saturated on write
	assign depth_sat = (cfg_wdata < DEPTH_MIN) ? DEPTH_MIN :
		(cfg_wdata > DEPTH_MAX) ? DEPTH_MAX : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_INIT;
		end else if (cfg_we) begin
			depth_q <= depth_sat;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
	end

	sfrp_calc u_calc (
		.req    (req_s1),
		.st     (state_q),
		.depth  (depth_q),
		.rsp    (rsp_nxt),
		.st_nxt (state_nxt)
	);

	// Transfer state follows each request as it moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= rsp_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sfrp_checker.sv
// Port-level checker for the SPI FIFO refill planner, bound to the top level
`default_nettype none

`include "spi_fifo_refill_planner_unit_defines.svh"

module sfrp_checker
	import sfrp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input sfrp_req_t  in_data,
	input logic       out_valid,
	input logic       out_ready,
	input sfrp_rsp_t  out_data,
	input logic       cfg_we,
	input logic [8:0] cfg_wdata
);

	logic unused_ok;
	assign unused_ok = in_valid ^ in_ready ^ (^in_data) ^ cfg_we ^ (^cfg_wdata);

	// A stalled result holds
	`SFRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

	// Completion leaves both interrupts off
	`SFRP_ASSERT_NOW(a_done_irqs_off, out_valid && out_data.done_res, !out_data.tx_empty_irq_on && !out_data.rx_full_irq_on, "done with interrupt enabled")

	// A start result moves no words and arms only transmit-empty
	`SFRP_ASSERT_NOW(a_start_shape, out_valid && out_data.tx_threshold != 8'd0, out_data.tx_empty_irq_on && !out_data.rx_full_irq_on && out_data.read_count == 9'd0 && out_data.write_count == 9'd0, "bad start result")

	// A receive threshold update only comes once sending is over
	`SFRP_ASSERT_NOW(a_rxth_phase, out_valid && out_data.rx_threshold_valid, !out_data.tx_empty_irq_on && out_data.rx_full_irq_on && !out_data.done_res, "threshold update out of phase")

endmodule

bind spi_fifo_refill_planner_unit sfrp_checker u_sfrp_checker (.*);

`default_nettype wire

FILE: dv/spi_fifo_refill_planner_unit_tb.sv
// Self-checking testbench for the SPI FIFO refill planner: transfer plans against a scoreboard
`default_nettype none

module spi_fifo_refill_planner_unit_tb;
	import sfrp_pkg::*;

	localparam int unsigned MAX_FIFO_DEPTH = 256;
	localparam int unsigned CYCLE_LIMIT    = 400000;
	localparam int unsigned PHASE_REQUESTS = 150;

	// Scoreboard: shadows the transfer state and queues the planned result of each request
	class refill_scoreboard;
		logic [8:0]  depth_reg;
		int unsigned tx_left;
		int unsigned rx_left;
		bit          tx_irq;
		bit          rx_irq;
		bit          busy;
		sfrp_rsp_t   plan_q[$];
		int unsigned mismatches;

		function new();
			depth_reg  = DEPTH_RESET;
			tx_left    = 0;
			rx_left    = 0;
			tx_irq     = 1'b0;
			rx_irq     = 1'b0;
			busy       = 1'b0;
			mismatches = 0;
		endfunction

		function void set_depth(logic [8:0] v);
			depth_reg = v;
		endfunction

		// Programmed depth, saturated into the supported range
		function int unsigned active_depth();
			int unsigned d;
			d = 32'(depth_reg);
			if (d < 32'(DEPTH_MIN))
				return 32'(DEPTH_MIN);
			if (d > MAX_FIFO_DEPTH)
				return MAX_FIFO_DEPTH;
			return d;
		endfunction

		function int unsigned umin(int unsigned a, int unsigned b);
			return (a < b) ? a : b;
		endfunction

		// Difference clamped at zero
		function int unsigned sub_floor(int unsigned a, int unsigned b);
			return (a > b) ? a - b : 0;
		endfunction

		// Plan one accepted request and queue the result it should give
		function void note_request(sfrp_req_t r);
			int unsigned d, rd, wr, lvl, room, gap, gap_room;
			sfrp_rsp_t   p;
			d = active_depth();
			p = '0;
			if (r.mode == MODE_START) begin
				if (r.word_count != 16'd0) begin
					tx_left = 32'(r.word_count);
					rx_left = 32'(r.word_count);
					p.tx_threshold = 8'(umin(d / 2, 32'(r.word_count)));
					tx_irq = 1'b1;
					rx_irq = 1'b0;
					busy   = 1'b1;
				end
			end else if ((r.irq_pending & IRQ_STATUS_MASK) != 5'd0 && busy) begin
				rd = umin(rx_left, 32'(r.rx_level));
				rx_left -= rd;
				p.read_count = 9'(rd);
				if (rx_left == 0) begin
					// last word drained: transfer complete
					tx_left = 0;
					tx_irq  = 1'b0;
					rx_irq  = 1'b0;
					busy    = 1'b0;
					p.done_res = 1'b1;
				end else begin
					lvl = umin(d, rx_left - 1);
					if (tx_left == 0) begin
						p.rx_threshold       = 9'(lvl);
						p.rx_threshold_valid = 1'b1;
					end else begin
						// push limited by words left, free room and in-flight gap
						room     = sub_floor(d, 32'(r.tx_level));
						gap      = sub_floor(rx_left, tx_left);
						gap_room = sub_floor(d, gap);
						wr = umin(umin(tx_left, room), gap_room);
						tx_left -= wr;
						p.write_count = 9'(wr);
						if (tx_left == 0) begin
							tx_irq = 1'b0;
							rx_irq = 1'b1;
							p.rx_threshold       = 9'(lvl);
							p.rx_threshold_valid = 1'b1;
						end
					end
				end
			end
			p.tx_empty_irq_on = tx_irq;
			p.rx_full_irq_on  = rx_irq;
			plan_q.push_back(p);
		endfunction

		function string describe(sfrp_rsp_t v);
			return $sformatf("rd=%0d wr=%0d rxth=%0d/%0d txth=%0d txirq=%0d rxirq=%0d done=%0d",
				v.read_count, v.write_count, v.rx_threshold, v.rx_threshold_valid,
				v.tx_threshold, v.tx_empty_irq_on, v.rx_full_irq_on, v.done_res);
		endfunction

		// Compare one accepted result with the oldest planned one
		function void check_response(sfrp_rsp_t got);
			sfrp_rsp_t want;
			if (plan_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %s", describe(got));
				return;
			end
			want = plan_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %s, actual %s",
						describe(want), describe(got));
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	sfrp_req_t  in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	sfrp_rsp_t  out_data;
	logic       cfg_we    = 1'b0;
	logic [8:0] cfg_wdata = '0;

	refill_scoreboard sb;
	bit               idle_on = 1'b1;
	int unsigned      stall_left = 0;
	int unsigned      requests_sent = 0;
	int unsigned      cycle_count;

	spi_fifo_refill_planner_unit #(
		.MAX_FIFO_DEPTH(MAX_FIFO_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver back-pressure in random bursts, started only while idling is enabled
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 7);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Handshake monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(in_data);
			if (out_valid && out_ready)
				sb.check_response(out_data);
		end
	end

	// Watchdog
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic sfrp_req_t make_req(logic mode, int unsigned cnt, int unsigned irq,
		int unsigned txl, int unsigned rxl);
		sfrp_req_t r;
		r.mode        = mode;
		r.word_count  = 16'(cnt);
		r.irq_pending = 5'(irq);
		r.tx_level    = 9'(txl);
		r.rx_level    = 9'(rxl);
		return r;
	endfunction

	// Any request at all, zero counts included
	function automatic sfrp_req_t random_req();
		int unsigned cnt;
		cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
		return make_req(1'($urandom_range(0, 1)), cnt, $urandom_range(0, 31),
			$urandom_range(0, 511), $urandom_range(0, 511));
	endfunction

	// Entered and left just after a falling edge with nothing yet driven in that step
	task automatic send_request(input sfrp_req_t r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_data  <= r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		requests_sent++;
	endtask

	// Hold the sender off until every planned result has been seen
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.plan_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_depth(input logic [8:0] v);
		wait_drained();
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_depth(v);
		@(negedge clk);
	endtask

	// One transfer: a start, then services until it completes or is abandoned, or else random requests
	task automatic run_transfer();
		int unsigned d, cnt, steps, irq, txl, rxl;
		d = sb.active_depth();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 5)) send_request(random_req());
			return;
		end
		if ($urandom_range(0, 7) == 0)
			wait_drained();
		case ($urandom_range(0, 9))
			0: cnt = $urandom_range(1, 65535);
			1: cnt = $urandom_range(1, 3);
			default: cnt = $urandom_range(1, 4 * d);
		endcase
		send_request(make_req(MODE_START, cnt, $urandom_range(0, 31),
			$urandom_range(0, 511), $urandom_range(0, 511)));
		steps = 0;
		while (sb.busy && steps < 48) begin
			if ($urandom_range(0, 15) == 0) begin
				send_request(random_req());
			end else begin
				irq = ($urandom_range(0, 3) == 0) ? (1 << $urandom_range(0, 4))
					: $urandom_range(1, 31);
				case ($urandom_range(0, 9))
					0: txl = $urandom_range(0, 511);
					1: txl = d;
					default: txl = $urandom_range(0, d);
				endcase
				case ($urandom_range(0, 9))
					0, 1, 2: rxl = 0;
					3: rxl = $urandom_range(0, 511);
					default: rxl = $urandom_range(0, d);
				endcase
				send_request(make_req(MODE_SERVICE, 0, irq, txl, rxl));
			end
			steps++;
		end
	endtask

	// Stimulus
	initial begin
		logic [8:0]  depth_plan[10];
		int unsigned phase_end;
		depth_plan = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd256, 9'd511, 9'd257, 9'd9, 9'd100, 9'd16};
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests at the reset depth of 16
		send_request(make_req(MODE_SERVICE, 0, 31, 0, 0));       // service while idle
		send_request(make_req(MODE_START, 0, 0, 0, 0));          // zero count ignored
		send_request(make_req(MODE_START, 1, 0, 0, 0));
		send_request(make_req(MODE_SERVICE, 0, 0, 0, 0));        // nothing pending
		send_request(make_req(MODE_SERVICE, 0, 1, 0, 0));        // last word pushed
		send_request(make_req(MODE_SERVICE, 0, 16, 0, 1));       // last word drained
		send_request(make_req(MODE_START, 65535, 31, 511, 511));
		send_request(make_req(MODE_SERVICE, 0, 4, 511, 0));      // no free room
		send_request(make_req(MODE_SERVICE, 0, 2, 0, 0));
		send_request(make_req(MODE_SERVICE, 0, 8, 0, 0));        // gap fills the FIFO
		send_request(make_req(MODE_START, 40, 0, 0, 0));         // restart while busy
		send_request(make_req(MODE_SERVICE, 0, 31, 256, 256));
		send_request(make_req(MODE_START, 20, 0, 0, 0));
		send_request(make_req(MODE_SERVICE, 0, 1, 0, 0));
		send_request(make_req(MODE_SERVICE, 0, 1, 12, 5));      // push ends, rx armed
		send_request(make_req(MODE_SERVICE, 0, 1, 0, 3));       // nothing left to send
		send_request(make_req(MODE_SERVICE, 0, 1, 0, 12));
		send_request(make_req(MODE_START, 32768, 0, 256, 0));
		send_request(make_req(MODE_SERVICE, 0, 16, 256, 511));
		send_request(make_req(MODE_START, 21845, 0, 0, 0));
		send_request(make_req(MODE_SERVICE, 0, 10, 170, 341));

		// Random transfers over a range of depths; phase 3 and the last phase run without idling
		foreach (depth_plan[i]) begin
			idle_on = (i != 3) && (i != $size(depth_plan) - 1);
			program_depth(depth_plan[i]);
			phase_end = requests_sent + PHASE_REQUESTS;
			while (requests_sent < phase_end)
				run_transfer();
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (sb.mismatches == 0 && sb.plan_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
